/* rtl/pp2l_pkg.sv */
// package for the point to polyline distance core
// types, codes and constants shared by all modules; no dependencies
`timescale 1ns / 1ps

package pp2l_pkg;

  localparam int COORD_W          = 24;
  localparam int DIST_W           = 24;
  localparam int MAX_VERTICES_DEF = 64;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // action codes of the input request
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  // pick one axis of a vertex
  function automatic logic signed [COORD_W-1:0] axis_of(vtx_t v, logic [1:0] i);
    logic signed [COORD_W-1:0] r;
    case (i)
      2'd0:    r = v.x;
      2'd1:    r = v.y;
      default: r = v.z;
    endcase
    return r;
  endfunction

endpackage

/* rtl/pp2l_in_if.sv */
// input channel: valid/ready handshake with action and coordinates
// depends on pp2l_pkg
`timescale 1ns / 1ps

interface pp2l_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      action;
  logic signed [pp2l_pkg::COORD_W-1:0] coord_x;
  logic signed [pp2l_pkg::COORD_W-1:0] coord_y;
  logic signed [pp2l_pkg::COORD_W-1:0] coord_z;

  modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface

/* rtl/pp2l_out_if.sv */
// result channel: valid/ready handshake with distance and flag
// depends on pp2l_pkg
`timescale 1ns / 1ps

interface pp2l_out_if;
  logic                         valid;
  logic                         ready;
  logic [pp2l_pkg::DIST_W-1:0]  distance;
  logic                         no_segment;

  modport source (output valid, distance, no_segment, input ready);
  modport sink   (input valid, distance, no_segment, output ready);
endinterface

/* rtl/pp2l_front.sv */
// front end: accepts requests, keeps the vertex count, issues vertex writes
// and queues query requests for the back end; depends on pp2l_pkg
`timescale 1ns / 1ps

module pp2l_front #(
  parameter int MAX_VERTICES = pp2l_pkg::MAX_VERTICES_DEF,
  parameter int AW = $clog2(MAX_VERTICES),
  parameter int CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  pp2l_in_if.sink            in_ch,
  input  logic               back_busy,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output pp2l_pkg::vtx_t     wr_vtx,
  output logic               q_valid,
  input  logic               q_pop,
  output pp2l_pkg::vtx_t     q_pt,
  output logic [CW-1:0]      q_cnt
);
  import pp2l_pkg::*;

  logic [CW-1:0] count_r;
  vtx_t          q_pt_r  [2];
  logic [CW-1:0] q_cnt_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    fill_r;
  logic          acc, push, is_query, is_edit;
  vtx_t          in_vtx;

  assign in_vtx   = '{x: in_ch.coord_x, y: in_ch.coord_y, z: in_ch.coord_z};
  assign is_query = (in_ch.action == ACT_QUERY);
  assign is_edit  = (in_ch.action == ACT_CLEAR) || (in_ch.action == ACT_APPEND);

  // edits wait until all earlier queries have finished reading the store
  always_comb begin
    if (is_query) in_ch.ready = (fill_r != 2'd2);
    else if (is_edit) in_ch.ready = (fill_r == 2'd0) && !back_busy;
    else in_ch.ready = 1'b1;
  end

  assign acc  = in_ch.valid && in_ch.ready;
  assign push = acc && is_query;

  // vertex write port
  assign wr_en   = acc && (in_ch.action == ACT_APPEND) && (count_r < CW'(MAX_VERTICES));
  assign wr_addr = count_r[AW-1:0];
  assign wr_vtx  = in_vtx;

  // vertex count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (acc && (in_ch.action == ACT_CLEAR)) begin
      count_r <= '0;
    end else if (wr_en) begin
      count_r <= count_r + CW'(1);
    end
  end

  // two entry query queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_pt_r[wp_r]  <= in_vtx;
      q_cnt_r[wp_r] <= count_r;
    end
  end

  assign q_valid = (fill_r != 2'd0);
  assign q_pt    = q_pt_r[rp_r];
  assign q_cnt   = q_cnt_r[rp_r];

endmodule

/* rtl/pp2l_back.sv */
// back end: vertex memory and the segment walk sequencer with divider,
// square root and result register; depends on pp2l_pkg
`timescale 1ns / 1ps

module pp2l_back #(
  parameter int MAX_VERTICES = pp2l_pkg::MAX_VERTICES_DEF,
  parameter int AW = $clog2(MAX_VERTICES),
  parameter int CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  pp2l_pkg::vtx_t     wr_vtx,
  input  logic               q_valid,
  output logic               q_pop,
  input  pp2l_pkg::vtx_t     q_pt,
  input  logic [CW-1:0]      q_cnt,
  output logic               busy,
  pp2l_out_if.source         out_ch
);
  import pp2l_pkg::*;

  localparam int D2W = 54;
  localparam int RW  = D2W / 2;

  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000_0000_0000_0001,
    S_WAITA = 16'b0000_0000_0000_0010,
    S_LATA  = 16'b0000_0000_0000_0100,
    S_WAITB = 16'b0000_0000_0000_1000,
    S_LATB  = 16'b0000_0000_0001_0000,
    S_MUL1  = 16'b0000_0000_0010_0000,
    S_MUL2  = 16'b0000_0000_0100_0000,
    S_SUM   = 16'b0000_0000_1000_0000,
    S_CLASS = 16'b0000_0001_0000_0000,
    S_DIV   = 16'b0000_0010_0000_0000,
    S_TMUL  = 16'b0000_0100_0000_0000,
    S_CPT   = 16'b0000_1000_0000_0000,
    S_SQ    = 16'b0001_0000_0000_0000,
    S_ACC   = 16'b0010_0000_0000_0000,
    S_SQRT  = 16'b0100_0000_0000_0000,
    S_OUT   = 16'b1000_0000_0000_0000
  } state_t;

  state_t              state_r;
  vtx_t                mem [MAX_VERTICES];
  vtx_t                rdata_r;
  logic [AW-1:0]       addr_r;
  vtx_t                p_r, a_r, b_r;
  logic [CW-1:0]       cnt_r;
  logic [AW-1:0]       idx_r;
  logic signed [24:0]  d_r [3];
  logic signed [24:0]  w_r [3];
  logic signed [55:0]  m_r [3];
  logic signed [27:0]  e_r [3];
  logic signed [27:0]  e_cpt [3];
  logic signed [27:0]  e_a [3];
  logic signed [27:0]  e_b [3];
  logic signed [51:0]  dot_r;
  logic [50:0]         len2_r;
  logic [51:0]         r_r, r_sh;
  logic [23:0]         t_r;
  logic [4:0]          k_r;
  logic [D2W-1:0]      best_r, d2_sum, d2_min;
  logic [D2W-1:0]      n_r;
  logic [RW+1:0]       rem_r, rem_sh, trial;
  logic [RW-1:0]       root_r, root_nxt;
  logic [DIST_W-1:0]   dist_r;
  logic                noseg_r;
  logic                last_seg;

  // vertex memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_vtx;
    rdata_r <= mem[addr_r];
  end

  // per axis arithmetic of the nearest point
  always_comb begin
    logic signed [55:0] rnd;
    logic signed [55:0] pe;
    for (int i = 0; i < 3; i++) begin
      rnd      = m_r[i] + 56'sd8388608;
      pe       = 56'(axis_of(p_r, 2'(i))) - 56'(axis_of(a_r, 2'(i))) - (rnd >>> 24);
      e_cpt[i] = pe[27:0];
      e_a[i]   = 28'(axis_of(p_r, 2'(i))) - 28'(axis_of(a_r, 2'(i)));
      e_b[i]   = 28'(axis_of(p_r, 2'(i))) - 28'(axis_of(b_r, 2'(i)));
    end
  end

  assign r_sh     = {r_r[50:0], 1'b0};
  assign d2_sum   = D2W'(m_r[0]) + D2W'(m_r[1]) + D2W'(m_r[2]);
  assign d2_min   = (d2_sum < best_r) ? d2_sum : best_r;
  assign last_seg = ((CW'(idx_r) + CW'(2)) == cnt_r);

  // square root digit step
  assign rem_sh   = {rem_r[RW-1:0], n_r[D2W-1:D2W-2]};
  assign trial    = {root_r, 2'b01};
  assign root_nxt = (rem_sh >= trial) ? {root_r[RW-2:0], 1'b1} : {root_r[RW-2:0], 1'b0};

  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign busy  = (state_r != S_IDLE);

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:  if (q_valid) state_r <= (q_cnt < CW'(2)) ? S_OUT : S_WAITA;
        S_WAITA: state_r <= S_LATA;
        S_LATA:  state_r <= S_WAITB;
        S_WAITB: state_r <= S_LATB;
        S_LATB:  state_r <= S_MUL1;
        S_MUL1:  state_r <= S_MUL2;
        S_MUL2:  state_r <= S_SUM;
        S_SUM:   state_r <= S_CLASS;
        S_CLASS: begin
          if (dot_r <= 52'sd0 || dot_r >= $signed({1'b0, len2_r})) state_r <= S_SQ;
          else state_r <= S_DIV;
        end
        S_DIV:   if (k_r == 5'd23) state_r <= S_TMUL;
        S_TMUL:  state_r <= S_CPT;
        S_CPT:   state_r <= S_SQ;
        S_SQ:    state_r <= S_ACC;
        S_ACC:   state_r <= last_seg ? S_SQRT : S_WAITB;
        S_SQRT:  if (k_r == 5'(RW - 1)) state_r <= S_OUT;
        S_OUT:   if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        p_r     <= q_pt;
        cnt_r   <= q_cnt;
        idx_r   <= '0;
        addr_r  <= '0;
        best_r  <= '1;
        dist_r  <= DIST_MAX;
        noseg_r <= 1'b1;
      end
      S_LATA: begin
        a_r    <= rdata_r;
        addr_r <= AW'(1);
      end
      S_LATB: begin
        b_r <= rdata_r;
        for (int i = 0; i < 3; i++) begin
          d_r[i] <= 25'(axis_of(rdata_r, 2'(i))) - 25'(axis_of(a_r, 2'(i)));
          w_r[i] <= 25'(axis_of(p_r, 2'(i))) - 25'(axis_of(a_r, 2'(i)));
        end
      end
      S_MUL1: begin
        for (int i = 0; i < 3; i++) m_r[i] <= 56'(w_r[i] * d_r[i]);
      end
      S_MUL2: begin
        dot_r <= 52'(m_r[0] + m_r[1] + m_r[2]);
        for (int i = 0; i < 3; i++) m_r[i] <= 56'(d_r[i] * d_r[i]);
      end
      S_SUM: len2_r <= 51'(m_r[0] + m_r[1] + m_r[2]);
      S_CLASS: begin
        r_r <= dot_r;
        t_r <= '0;
        k_r <= '0;
        for (int i = 0; i < 3; i++) e_r[i] <= (dot_r <= 52'sd0) ? e_a[i] : e_b[i];
      end
      S_DIV: begin
        k_r <= k_r + 5'd1;
        if (r_sh >= {1'b0, len2_r}) begin
          r_r <= r_sh - {1'b0, len2_r};
          t_r <= {t_r[22:0], 1'b1};
        end else begin
          r_r <= r_sh;
          t_r <= {t_r[22:0], 1'b0};
        end
      end
      S_TMUL: begin
        for (int i = 0; i < 3; i++) m_r[i] <= 56'($signed({1'b0, t_r}) * d_r[i]);
      end
      S_CPT: begin
        for (int i = 0; i < 3; i++) e_r[i] <= e_cpt[i];
      end
      S_SQ: begin
        for (int i = 0; i < 3; i++) m_r[i] <= 56'(e_r[i] * e_r[i]);
      end
      S_ACC: begin
        best_r <= d2_min;
        n_r    <= d2_min;
        rem_r  <= '0;
        root_r <= '0;
        k_r    <= '0;
        a_r    <= b_r;
        idx_r  <= idx_r + AW'(1);
        addr_r <= AW'(CW'(idx_r) + CW'(2));
      end
      S_SQRT: begin
        k_r    <= k_r + 5'd1;
        n_r    <= {n_r[D2W-3:0], 2'b00};
        rem_r  <= (rem_sh >= trial) ? rem_sh - trial : rem_sh;
        root_r <= root_nxt;
        if (k_r == 5'(RW - 1)) begin
          dist_r  <= (root_nxt > RW'(DIST_MAX)) ? DIST_MAX : root_nxt[DIST_W-1:0];
          noseg_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // result register
  assign out_ch.valid      = (state_r == S_OUT);
  assign out_ch.distance   = dist_r;
  assign out_ch.no_segment = noseg_r;

endmodule

/* rtl/point_to_polyline_distance_core.sv */
// top level of the point to polyline distance core
// depends on pp2l_pkg, pp2l_in_if, pp2l_out_if, pp2l_front, pp2l_back
//
// usage
//   in_ch carries requests: action 0 clears the polyline, action 1 appends
//   the vertex in coord_x/y/z (dropped when the store is full), action 2
//   queries the distance from the point in coord_x/y/z. only a query gives
//   a result on out_ch: distance (Q16.8, saturated) and no_segment.
//   a query is queued (two deep) at once; clear and append wait until all
//   queued queries have finished walking the vertex memory.
// sequence
//   a query over n vertices reads the first vertex, then per segment takes
//   an endpoint when the projection falls outside it or runs the divider
//   for the projection, and ends with the square root and the result;
//   fewer than two vertices answer with no walk. the multiply lanes are
//   shared and the divider and square root work one bit per step. one
//   query is in work at a time.
// reset and stalls
//   rst_n clears the vertex count, the queue and the sequencer; the vertex
//   memory itself keeps stale data. a result holds on out_ch until taken,
//   and the front keeps accepting queries while queue space remains.
`timescale 1ns / 1ps

module point_to_polyline_distance_core #(
  parameter int MAX_VERTICES = pp2l_pkg::MAX_VERTICES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  pp2l_in_if.sink    in_ch,
  pp2l_out_if.source out_ch
);
  import pp2l_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic          wr_en, q_valid, q_pop, back_busy;
  logic [AW-1:0] wr_addr;
  vtx_t          wr_vtx, q_pt;
  logic [CW-1:0] q_cnt;

  // request intake and query queue
  pp2l_front #(.MAX_VERTICES(MAX_VERTICES), .AW(AW), .CW(CW)) u_front (
    .clk, .rst_n, .in_ch, .back_busy, .wr_en, .wr_addr, .wr_vtx,
    .q_valid, .q_pop, .q_pt, .q_cnt
  );

  // segment walk and result
  pp2l_back #(.MAX_VERTICES(MAX_VERTICES), .AW(AW), .CW(CW)) u_back (
    .clk, .rst_n, .wr_en, .wr_addr, .wr_vtx, .q_valid, .q_pop, .q_pt, .q_cnt,
    .busy(back_busy), .out_ch
  );

endmodule

/* rtl/pp2l_checker.sv */
// port level checks for the point to polyline distance core
// depends on pp2l_pkg; bound to point_to_polyline_distance_core
`timescale 1ns / 1ps

module pp2l_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pp2l_pkg::DIST_W-1:0] out_distance,
  input logic                        out_no_segment
);
  import pp2l_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_distance) && $stable(out_no_segment))
    else $error("result changed while stalled");

  // a result without a segment reports the saturated distance
  a_noseg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_segment |-> out_distance == DIST_MAX)
    else $error("no_segment without saturated distance");

  // no result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind point_to_polyline_distance_core pp2l_checker u_pp2l_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_distance   (out_ch.distance),
  .out_no_segment (out_ch.no_segment)
);
